// File: design/dqi_pkg.sv
package dqi_pkg;

  // Storage geometry.
  localparam int unsigned CAPACITY   = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W      = $clog2(CAPACITY + 1);

  // Field widths of the stream words.
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned FILL_W   = 5;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

  localparam int unsigned S_TDATA_W = ((VALUE_W + POS_W + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W = ((VALUE_W + FILL_W + 7) / 8) * 8;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_POP_FRONT  = 3'd1,
    FN_PUSH_BACK  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_READ       = 3'd4,
    FN_DELETE     = 3'd5,
    FN_REVERSE    = 3'd6,
    FN_CLEAR      = 3'd7
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SHIFT_NONE,
    SHIFT_INSERT,
    SHIFT_REMOVE
  } shift_e;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    shift_e             kind;
    logic [IDX_W-1:0]   pos;
  } shift_cmd_t;

endpackage

// File: design/dqi_cell.sv
module dqi_cell (
  input  logic                            clk_i,
  input  logic [dqi_pkg::IDX_W-1:0]       cell_idx_i,
  input  dqi_pkg::shift_cmd_t             cmd_i,
  input  logic [dqi_pkg::DATA_WIDTH-1:0]  push_data_i,
  input  logic [dqi_pkg::DATA_WIDTH-1:0]  low_data_i,
  input  logic [dqi_pkg::DATA_WIDTH-1:0]  high_data_i,
  output logic [dqi_pkg::DATA_WIDTH-1:0]  data_o
);
  import dqi_pkg::*;

  logic [DATA_WIDTH-1:0] data_q, data_d;

  // An insert opens a slot at pos by moving everything above it up by one;
  // a remove closes the slot at pos by pulling everything above it down.
  always_comb begin
    data_d = data_q;
    unique case (cmd_i.kind)
      SHIFT_INSERT: begin
        if (cell_idx_i == cmd_i.pos) begin
          data_d = push_data_i;
        end else if (cell_idx_i > cmd_i.pos) begin
          data_d = low_data_i;
        end
      end
      SHIFT_REMOVE: begin
        if (cell_idx_i >= cmd_i.pos) begin
          data_d = high_data_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// File: design/bounded_deque_indexed_delete_unit.sv
// An accepted word's result word is registered and shows on the master
// side right after the edge that accepts it. Throughput: one word per
// cycle unless the master side stalls; every operation, including a delete
// that closes a gap, is at most a single parallel shift of the cell chain.
// Reset clears the fill count, the direction flag and the result valid flag;
// cell contents are not cleared and are only read below the fill count.
module bounded_deque_indexed_delete_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // s_axis_tdata: value_in [31:0], position [35:32], zero padding above.
  input  logic [dqi_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // s_axis_tuser: func [2:0].
  input  logic [dqi_pkg::FUNC_W-1:0]      s_axis_tuser,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // m_axis_tdata: value_out [31:0], fill_count [36:32], zero padding above.
  output logic [dqi_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // m_axis_tuser: status [1:0].
  output logic [dqi_pkg::STATUS_W-1:0]    m_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready
);
  import dqi_pkg::*;

  logic [CNT_W-1:0]      count_q, count_d;
  logic                  rev_q, rev_d;
  logic                  m_valid_q;
  logic [VALUE_W-1:0]    out_value_q;
  logic [FILL_W-1:0]     out_count_q;
  status_e               out_status_q;

  logic                  accept;
  func_e                 func;
  logic [VALUE_W-1:0]    value_in;
  logic [POS_W-1:0]      position;
  logic [DATA_WIDTH-1:0] push_data;
  logic [IDX_W-1:0]      logical_idx, phys_idx;
  logic [DATA_WIDTH-1:0] rd_data;
  logic                  pos_bad, at_low;
  shift_cmd_t            cmd;
  logic [VALUE_W-1:0]    res_value;
  status_e               res_status;

  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign func     = func_e'(s_axis_tuser);
  assign value_in = s_axis_tdata[VALUE_W-1:0];
  assign position = s_axis_tdata[VALUE_W +: POS_W];
  assign push_data = DATA_WIDTH'(value_in);

  assign s_axis_tready = !m_valid_q || m_axis_tready;

  // The chain is ordered by physical place; the direction flag says which
  // end is the logical front.
  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [DATA_WIDTH-1:0] low_data, high_data;
      if (gi == 0) begin : g_first
        assign low_data = push_data;
      end else begin : g_mid_lo
        assign low_data = cell_data[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign high_data = '0;
      end else begin : g_mid_hi
        assign high_data = cell_data[gi+1];
      end
      dqi_cell u_cell (
        .clk_i       (clk_i),
        .cell_idx_i  (IDX_W'(gi)),
        .cmd_i       (cmd),
        .push_data_i (push_data),
        .low_data_i  (low_data),
        .high_data_i (high_data),
        .data_o      (cell_data[gi])
      );
    end
  endgenerate

  always_comb begin
    unique case (func)
      FN_POP_BACK:          logical_idx = IDX_W'(count_q - CNT_W'(1));
      FN_READ, FN_DELETE:   logical_idx = IDX_W'(position);
      default:              logical_idx = '0;
    endcase
  end

  assign phys_idx = rev_q ? IDX_W'(count_q - CNT_W'(1) - CNT_W'(logical_idx)) : logical_idx;
  assign rd_data  = cell_data[phys_idx];
  assign pos_bad  = CMP_W'(position) >= CMP_W'(count_q);
  assign at_low   = (func == FN_PUSH_FRONT) != rev_q;

  always_comb begin
    cmd.kind   = SHIFT_NONE;
    cmd.pos    = phys_idx;
    res_value  = '0;
    res_status = ST_OK;
    count_d    = count_q;
    rev_d      = rev_q;
    unique case (func)
      FN_PUSH_FRONT, FN_PUSH_BACK: begin
        if (count_q == CNT_W'(CAPACITY)) begin
          res_status = ST_FULL;
        end else begin
          cmd.kind = SHIFT_INSERT;
          cmd.pos  = at_low ? '0 : IDX_W'(count_q);
          count_d  = count_q + CNT_W'(1);
        end
      end
      FN_POP_FRONT, FN_POP_BACK: begin
        if (count_q == '0) begin
          res_status = ST_EMPTY;
        end else begin
          cmd.kind  = SHIFT_REMOVE;
          res_value = VALUE_W'(rd_data);
          count_d   = count_q - CNT_W'(1);
        end
      end
      FN_READ: begin
        if (pos_bad) begin
          res_status = ST_BAD_INDEX;
        end else begin
          res_value = VALUE_W'(rd_data);
        end
      end
      FN_DELETE: begin
        if (pos_bad) begin
          res_status = ST_BAD_INDEX;
        end else begin
          cmd.kind  = SHIFT_REMOVE;
          res_value = VALUE_W'(rd_data);
          count_d   = count_q - CNT_W'(1);
        end
      end
      FN_REVERSE: rev_d = !rev_q;
      FN_CLEAR: begin
        count_d = '0;
        rev_d   = 1'b0;
      end
      default: count_d = count_q;
    endcase
    // The chain only moves for a word that is really taken.
    if (!accept) begin
      cmd.kind = SHIFT_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      rev_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q   <= count_d;
        rev_q     <= rev_d;
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_value_q  <= res_value;
      out_count_q  <= FILL_W'(count_d);
      out_status_q <= res_status;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = M_TDATA_W'({out_count_q, out_value_q});
  assign m_axis_tuser  = out_status_q;

endmodule

// File: design/dqi_checker.sv
module dqi_port_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic [dqi_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  input logic [dqi_pkg::FUNC_W-1:0]      s_axis_tuser,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [dqi_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  input logic [dqi_pkg::STATUS_W-1:0]    m_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready
);
  import dqi_pkg::*;

  logic [VALUE_W-1:0] out_value;
  logic [FILL_W-1:0]  out_fill;

  assign out_value = m_axis_tdata[VALUE_W-1:0];
  assign out_fill  = m_axis_tdata[VALUE_W +: FILL_W];

  // A stalled result word holds still.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // Every accepted word yields a result word in the next cycle.
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted word produced no result");

  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> FILL_W'(CAPACITY) >= out_fill)
    else $error("fill count above capacity");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ST_FULL |->
      out_fill == FILL_W'(CAPACITY) && out_value == '0)
    else $error("full status with room left");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ST_EMPTY |-> out_fill == '0 && out_value == '0)
    else $error("empty status with stored words");

endmodule

bind bounded_deque_indexed_delete_unit dqi_port_checker u_dqi_port_checker (.*);

// File: test/dqi_checker.sv
module dqi_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // s_tdata_i: value_in [31:0], position [35:32], zero padding above.
  input  logic [dqi_pkg::S_TDATA_W-1:0] s_tdata_i,
  // s_tuser_i: func [2:0].
  input  logic [dqi_pkg::FUNC_W-1:0]    s_tuser_i,
  input  logic                          s_tvalid_i,
  input  logic                          s_tready_i,
  // m_tdata_i: value_out [31:0], fill_count [36:32], zero padding above.
  input  logic [dqi_pkg::M_TDATA_W-1:0] m_tdata_i,
  // m_tuser_i: status [1:0].
  input  logic [dqi_pkg::STATUS_W-1:0]  m_tuser_i,
  input  logic                          m_tvalid_i,
  input  logic                          m_tready_i,
  output int unsigned                   mismatch_count_o,
  output int unsigned                   replies_pending_o
);
  import dqi_pkg::*;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [FILL_W-1:0]  fill;
    status_e            status;
  } deque_reply_t;

  // Shadow copy of the deque, kept in the same physical order as the cell chain.
  logic [DATA_WIDTH-1:0] shadow_cells [CAPACITY];
  int                    shadow_fill;
  bit                    shadow_reversed;
  deque_reply_t          awaited_replies [$];
  int unsigned           mismatches;
  int unsigned           reply_index;

  function automatic int phys_slot(input int logical);
    return shadow_reversed ? shadow_fill - 1 - logical : logical;
  endfunction

  function automatic logic [DATA_WIDTH-1:0] take_slot(input int slot);
    logic [DATA_WIDTH-1:0] taken;
    taken = shadow_cells[slot];
    for (int k = slot; k + 1 < shadow_fill; k++) begin
      shadow_cells[k] = shadow_cells[k + 1];
    end
    shadow_fill--;
    return taken;
  endfunction

  task automatic predict_op(input func_e op, input logic [VALUE_W-1:0] val,
                            input logic [POS_W-1:0] pos, output deque_reply_t reply);
    int slot;
    bit at_low;
    reply.value  = '0;
    reply.status = ST_OK;
    case (op)
      FN_PUSH_FRONT, FN_PUSH_BACK: begin
        if (shadow_fill >= CAPACITY) begin
          reply.status = ST_FULL;
        end else begin
          // With the direction flipped, the logical front sits at the high end.
          at_low = (op == FN_PUSH_FRONT) != shadow_reversed;
          slot = at_low ? 0 : shadow_fill;
          for (int k = shadow_fill; k > slot; k--) begin
            shadow_cells[k] = shadow_cells[k - 1];
          end
          shadow_cells[slot] = val[DATA_WIDTH-1:0];
          shadow_fill++;
        end
      end
      FN_POP_FRONT, FN_POP_BACK: begin
        if (shadow_fill == 0) begin
          reply.status = ST_EMPTY;
        end else begin
          slot = phys_slot((op == FN_POP_FRONT) ? 0 : shadow_fill - 1);
          reply.value = VALUE_W'(take_slot(slot));
        end
      end
      FN_READ, FN_DELETE: begin
        if (int'(pos) >= shadow_fill) begin
          reply.status = ST_BAD_INDEX;
        end else if (op == FN_READ) begin
          reply.value = VALUE_W'(shadow_cells[phys_slot(int'(pos))]);
        end else begin
          reply.value = VALUE_W'(take_slot(phys_slot(int'(pos))));
        end
      end
      FN_REVERSE: begin
        shadow_reversed = !shadow_reversed;
      end
      default: begin
        shadow_fill     = 0;
        shadow_reversed = 1'b0;
      end
    endcase
    reply.fill = FILL_W'(shadow_fill);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track_words
    deque_reply_t want;
    deque_reply_t got;
    if (!rst_ni) begin
      shadow_fill     = 0;
      shadow_reversed = 1'b0;
      mismatches      = 0;
      reply_index     = 0;
      awaited_replies.delete();
      mismatch_count_o  <= 0;
      replies_pending_o <= 0;
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        predict_op(func_e'(s_tuser_i), s_tdata_i[VALUE_W-1:0], s_tdata_i[VALUE_W +: POS_W],
                   want);
        awaited_replies.push_back(want);
      end
      if (m_tvalid_i && m_tready_i) begin
        got.value  = m_tdata_i[VALUE_W-1:0];
        got.fill   = m_tdata_i[VALUE_W +: FILL_W];
        got.status = status_e'(m_tuser_i);
        if (awaited_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result word %0d arrived with nothing outstanding", $time,
                     reply_index);
          end
        end else begin
          want = awaited_replies.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result word %0d expected value %h fill %0d status %0d, got %s",
                       $time, reply_index, want.value, want.fill, want.status,
                       $sformatf("value %h fill %0d status %0d", got.value, got.fill,
                                 got.status));
            end
          end
        end
        reply_index++;
      end
      mismatch_count_o  <= mismatches;
      replies_pending_o <= awaited_replies.size();
    end
  end

endmodule

// File: test/tb_top.sv
module tb_top;
  import dqi_pkg::*;

  logic                 clk_i;
  logic                 rst_ni;
  // s_axis_tdata: value_in [31:0], position [35:32], zero padding above.
  logic [S_TDATA_W-1:0] s_axis_tdata;
  // s_axis_tuser: func [2:0].
  logic [FUNC_W-1:0]    s_axis_tuser;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  // m_axis_tdata: value_out [31:0], fill_count [36:32], zero padding above.
  logic [M_TDATA_W-1:0] m_axis_tdata;
  // m_axis_tuser: status [1:0].
  logic [STATUS_W-1:0]  m_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;

  int unsigned mismatch_count;
  int unsigned replies_pending;
  bit          steady = 1'b0;
  int unsigned burst_left;
  int unsigned rx_run = 0;
  bit          rx_ready = 1'b0;

  bounded_deque_indexed_delete_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  dqi_checker i_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .s_tdata_i         (s_axis_tdata),
    .s_tuser_i         (s_axis_tuser),
    .s_tvalid_i        (s_axis_tvalid),
    .s_tready_i        (s_axis_tready),
    .m_tdata_i         (m_axis_tdata),
    .m_tuser_i         (m_axis_tuser),
    .m_tvalid_i        (m_axis_tvalid),
    .m_tready_i        (m_axis_tready),
    .mismatch_count_o  (mismatch_count),
    .replies_pending_o (replies_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Random-length ready and stall runs alternate; steady phases stay ready.
  always @(posedge clk_i) begin
    if (rx_run == 0) begin
      rx_ready = steady ? 1'b1 : !rx_ready;
      rx_run   = rx_ready ? $urandom_range(1, 10) : $urandom_range(1, 6);
    end else begin
      rx_run--;
    end
    m_axis_tready <= rx_ready;
  end

  task automatic send_op(input func_e op, input logic [VALUE_W-1:0] val,
                         input logic [POS_W-1:0] pos);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = steady ? 0 : $urandom_range(0, 9);
      burst_left = steady ? 1000 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tdata  <= {{(S_TDATA_W - VALUE_W - POS_W){1'b0}}, pos, val};
    s_axis_tuser  <= op;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
  endtask

  // Hold off the sender until every outstanding result word has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (replies_pending != 0) @(posedge clk_i);
    burst_left = 0;
  endtask

  initial begin
    func_e                op;
    logic [VALUE_W-1:0]   val;
    logic [POS_W-1:0]     pos;
    int unsigned          roll;
    int unsigned          push_pct;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FN_CLEAR;
    burst_left    = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty-queue corner cases.
    send_op(FN_POP_FRONT, '1, '0);
    send_op(FN_POP_BACK, '0, '0);
    send_op(FN_READ, '0, '0);
    send_op(FN_DELETE, '1, '1);
    send_op(FN_REVERSE, '0, '0);
    // Fill to capacity from both ends, with all-zero and all-one values first.
    for (int i = 0; i < CAPACITY; i++) begin
      val = (i == 0) ? '0 : (i == 1) ? '1 : VALUE_W'($urandom());
      send_op(i[0] ? FN_PUSH_FRONT : FN_PUSH_BACK, val, POS_W'(i));
    end
    send_op(FN_PUSH_BACK, 32'hdead_beef, '0);
    send_op(FN_READ, '0, '1);
    send_op(FN_DELETE, '0, '1);
    send_op(FN_REVERSE, '0, '0);
    send_op(FN_DELETE, '0, POS_W'(3));
    send_op(FN_POP_FRONT, '0, '0);
    send_op(FN_POP_BACK, '0, '0);
    send_op(FN_CLEAR, '1, '1);
    drain_results();

    // Random phases cycle through growing, balanced and shrinking mixes.
    for (int phase = 0; phase < 8; phase++) begin
      steady     <= (phase == 3) || (phase == 6);
      burst_left = 0;
      push_pct   = (phase % 3 == 0) ? 60 : (phase % 3 == 1) ? 40 : 25;
      for (int n = 0; n < 120; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < push_pct) begin
          op = $urandom_range(0, 1) ? FN_PUSH_FRONT : FN_PUSH_BACK;
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < 46) begin
            op = $urandom_range(0, 1) ? FN_POP_FRONT : FN_POP_BACK;
          end else if (roll < 71) begin
            op = FN_READ;
          end else if (roll < 89) begin
            op = FN_DELETE;
          end else if (roll < 99) begin
            op = FN_REVERSE;
          end else begin
            op = FN_CLEAR;
          end
        end
        if ($urandom_range(0, 9) == 0) begin
          val = $urandom_range(0, 1) ? '1 : '0;
        end else begin
          val = VALUE_W'($urandom());
        end
        pos = $urandom_range(0, 1) ? POS_W'($urandom_range(0, 15)) : POS_W'($urandom_range(0, 5));
        send_op(op, val, pos);
      end
      drain_results();
    end

    repeat (6) @(posedge clk_i);
    if (mismatch_count == 0 && replies_pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

// File: sim.f
design/dqi_pkg.sv
design/dqi_cell.sv
design/bounded_deque_indexed_delete_unit.sv
design/dqi_checker.sv
test/dqi_checker.sv
test/tb_top.sv
